### design/cht_pkg.sv
package cht_pkg;

  localparam int unsigned TableDepthDefault = 1024;

  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = 3;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] RegModulus = 3'd0;
  localparam logic [RegIdxW-1:0] RegQuad1   = 3'd1;
  localparam logic [RegIdxW-1:0] RegLin1    = 3'd2;
  localparam logic [RegIdxW-1:0] RegOff1    = 3'd3;
  localparam logic [RegIdxW-1:0] RegQuad2   = 3'd4;
  localparam logic [RegIdxW-1:0] RegLin2    = 3'd5;
  localparam logic [RegIdxW-1:0] RegOff2    = 3'd6;
  localparam logic [RegIdxW-1:0] RegKicks   = 3'd7;

  // Commands
  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdDelete = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [15:0] ModulusReset = 16'd1031;
  localparam logic [12:0] KicksReset   = 13'd2048;

  // Hash coefficients for one table
  typedef struct packed {
    logic [15:0] quad;
    logic [15:0] lin;
    logic [15:0] off;
  } coeff_t;

endpackage

### design/cht_ram.sv
module cht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cht_hash.sv
// Sequential hash unit: shift-subtract modulo over one shared adder, with a
// 16x16 multiplier used once per step. Computes ((q*k*k + l*k + o) mod p) for
// k = key mod p, then folds the result into the table range: the low index
// bits for a power-of-two depth, one more reduction pass otherwise.
module cht_hash
  import cht_pkg::*;
#(
  parameter int unsigned IdxW  = 10,
  parameter int unsigned Depth = TableDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [31:0]     key,
  input  logic [15:0]     modulus,
  input  coeff_t          coeff,
  output logic            done,
  output logic [IdxW-1:0] slot
);

  localparam bit          DepthPow2 = (Depth & (Depth - 1)) == 0;
  localparam logic [16:0] DepthVal  = 17'(Depth);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_MUL, S_RED2, S_FIN
  } state_t;

  state_t      state;
  logic [48:0] rem;     // value under reduction
  logic [5:0]  bitpos;  // shift position of the divisor
  logic [15:0] kmod;
  logic [15:0] acc;
  logic [1:0]  phase;   // which Horner step
  logic        by_depth;
  logic [16:0] divisor;
  logic [48:0] sub;
  logic [48:0] shifted;
  logic [31:0] prod;

  assign divisor = by_depth ? DepthVal : {1'b0, modulus};
  assign shifted = {32'd0, divisor} << bitpos;
  assign sub     = rem - shifted;
  assign prod    = acc * ((phase == 2'd0) ? coeff.quad : kmod);

  // Sequence Horner steps, each followed by a bit-serial reduction
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      by_depth <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= start && (modulus == 16'd0);
          if (start) begin
            if (modulus == 16'd0) begin
              slot  <= '0;
            end else begin
              rem      <= {17'd0, key};
              bitpos   <= 6'd32;
              phase    <= 2'd0;
              by_depth <= 1'b0;
              state    <= S_RED;
            end
          end
        end
        S_RED, S_RED2: begin
          done <= 1'b0;
          if (sub <= rem) begin
            rem <= sub;
          end
          if (bitpos == 6'd0) begin
            state <= S_MUL;
          end else begin
            bitpos <= bitpos - 6'd1;
          end
        end
        S_MUL: begin
          // rem now holds a value below the divisor
          unique case (phase)
            2'd0: begin
              done  <= 1'b0;
              kmod  <= rem[15:0];
              acc   <= 16'd1;
              phase <= 2'd1;
              // reduce quad before it meets k
              rem   <= {33'd0, coeff.quad};
              bitpos<= 6'd16;
              state <= S_RED;
            end
            2'd1: begin
              // t = (q mod p)*k + l
              done   <= 1'b0;
              acc    <= rem[15:0];
              phase  <= 2'd2;
              state  <= S_FIN;
            end
            2'd2: begin
              done   <= 1'b0;
              acc    <= rem[15:0];
              phase  <= 2'd3;
              state  <= S_FIN;
            end
            default: begin
              if (DepthPow2 || by_depth) begin
                slot     <= rem[IdxW-1:0];
                done     <= 1'b1;
                by_depth <= 1'b0;
                state    <= S_IDLE;
              end else begin
                // fold the residue into the table range
                done     <= 1'b0;
                by_depth <= 1'b1;
                bitpos   <= 6'd16;
                state    <= S_RED;
              end
            end
          endcase
        end
        S_FIN: begin
          // rem = acc*k + term, then reduce
          done   <= 1'b0;
          rem    <= {17'd0, prod} + {33'd0, (phase == 2'd2) ? coeff.lin : coeff.off};
          bitpos <= 6'd33;
          state  <= S_RED2;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/cuckoo_hash_table_top.sv
// A hash pass runs the key through the sequential hash unit; lookup and delete run two passes
// plus the slot reads before the result shows, and a new word is taken only once the result
// is accepted. Insert repeats both passes and the slot reads for each eviction round, until a
// key is placed or max_kicks evictions are made; a depth that is not a power of two adds a fold
// pass to each hash. Unused commands and a zero kick limit answer on the next cycle. Reset runs
// a clearing pass over the valid memories first; configuration returns to reset values.
module cuckoo_hash_table_top
  import cht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RegIdxW-1:0]  cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [31:0]         key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic                status,
  output logic [31:0]         homeless_key
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_H1, S_H2, S_RD, S_RDW, S_DEC, S_OUT
  } state_t;

  state_t      state;
  logic [15:0] modulus;
  coeff_t      c1, c2;
  logic [12:0] max_kicks;
  logic [1:0]  op;
  logic [31:0] carried;
  logic [12:0] round;
  logic [IdxW-1:0] h1, h2, clr;

  logic        hstart, hdone;
  coeff_t      hco;
  logic [IdxW-1:0] hslot;
  logic        hsel;

  logic        k1_we, k2_we, v1_we, v2_we, v1_wd, v2_wd;
  logic [31:0] k1_wd, k2_wd, k1_rd, k2_rd;
  logic [IdxW-1:0] v_wa1, v_wa2;
  logic        v1_rd, v2_rd;
  logic        hit1, hit2;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign hco       = hsel ? c2 : c1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= ModulusReset;
      c1        <= '{quad: 16'd3, lin: 16'd5, off: 16'd7};
      c2        <= '{quad: 16'd11, lin: 16'd13, off: 16'd17};
      max_kicks <= KicksReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegModulus: modulus   <= cfg_data;
        RegQuad1:   c1.quad   <= cfg_data;
        RegLin1:    c1.lin    <= cfg_data;
        RegOff1:    c1.off    <= cfg_data;
        RegQuad2:   c2.quad   <= cfg_data;
        RegLin2:    c2.lin    <= cfg_data;
        RegOff2:    c2.off    <= cfg_data;
        RegKicks:   max_kicks <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  cht_hash #(.IdxW(IdxW), .Depth(TABLE_DEPTH)) u_hash (
    .clk, .rst, .start(hstart), .key(carried), .modulus,
    .coeff(hco), .done(hdone), .slot(hslot)
  );

  cht_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_k1 (
    .clk, .we(k1_we), .waddr(h1), .wdata(k1_wd), .raddr(h1), .rdata(k1_rd));
  cht_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_k2 (
    .clk, .we(k2_we), .waddr(h2), .wdata(k2_wd), .raddr(h2), .rdata(k2_rd));
  cht_ram #(.Width(1), .Depth(TABLE_DEPTH)) u_v1 (
    .clk, .we(v1_we), .waddr(v_wa1), .wdata(v1_wd), .raddr(h1), .rdata(v1_rd));
  cht_ram #(.Width(1), .Depth(TABLE_DEPTH)) u_v2 (
    .clk, .we(v2_we), .waddr(v_wa2), .wdata(v2_wd), .raddr(h2), .rdata(v2_rd));

  assign hit1 = v1_rd && (k1_rd == carried);
  assign hit2 = v2_rd && (k2_rd == carried);
  assign v_wa1 = (state == S_CLR) ? clr : h1;
  assign v_wa2 = v_wa1 == clr && state == S_CLR ? clr : h2;

  // Decide memory writes from the slots just read
  always_comb begin
    k1_we = 1'b0; k2_we = 1'b0; v1_we = 1'b0; v2_we = 1'b0;
    v1_wd = 1'b0; v2_wd = 1'b0;
    k1_wd = carried; k2_wd = carried;
    if (state == S_CLR) begin
      v1_we = 1'b1; v2_we = 1'b1;
    end else if (state == S_DEC) begin
      priority case (op)
        CmdDelete: begin
          v1_we = hit1;
          v2_we = hit2;
        end
        CmdInsert: begin
          if (!v1_rd) begin
            k1_we = 1'b1; v1_we = 1'b1; v1_wd = 1'b1;
          end else if (!v2_rd) begin
            k2_we = 1'b1; v2_we = 1'b1; v2_wd = 1'b1;
          end else if (!round[0]) begin
            k1_we = 1'b1;
          end else begin
            k2_we = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequence hashing, reads and eviction rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      out_valid <= 1'b0;
      hsel      <= 1'b0;
      hstart    <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          hstart <= 1'b0;
          clr <= clr + 1'b1;
          if (clr == IdxW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op      <= cmd;
            carried <= key;
            round   <= '0;
            found   <= 1'b0;
            if (cmd == CmdInsert && max_kicks == 13'd0) begin
              status       <= 1'b1;
              homeless_key <= key;
              hstart       <= 1'b0;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end else if (cmd == CmdLookup || cmd == CmdInsert || cmd == CmdDelete) begin
              status       <= 1'b0;
              homeless_key <= '0;
              hsel         <= 1'b0;
              hstart       <= 1'b1;
              state        <= S_H1;
            end else begin
              status       <= 1'b0;
              homeless_key <= '0;
              hstart       <= 1'b0;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end
          end else begin
            hstart <= 1'b0;
          end
        end
        S_H1: begin
          hstart <= hdone;
          if (hdone) begin
            h1     <= hslot;
            hsel   <= 1'b1;
            state  <= S_H2;
          end
        end
        S_H2: begin
          hstart <= 1'b0;
          if (hdone) begin
            h2    <= hslot;
            state <= S_RD;
          end
        end
        S_RD: begin
          hstart <= 1'b0;
          state  <= S_RDW;
        end
        S_RDW: begin
          hstart <= 1'b0;
          state  <= S_DEC;
        end
        S_DEC: begin
          if (op == CmdLookup) begin
            found     <= hit1 || hit2;
            hstart    <= 1'b0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (op == CmdDelete || !v1_rd || !v2_rd) begin
            hstart    <= 1'b0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            carried <= round[0] ? k2_rd : k1_rd;
            round   <= round + 13'd1;
            if (round + 13'd1 == max_kicks) begin
              status       <= 1'b1;
              homeless_key <= round[0] ? k2_rd : k1_rd;
              hstart       <= 1'b0;
              out_valid    <= 1'b1;
              state        <= S_OUT;
            end else begin
              hsel   <= 1'b0;
              hstart <= 1'b1;
              state  <= S_H1;
            end
          end
        end
        S_OUT: begin
          hstart <= 1'b0;
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          hstart <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  // Result only shown in its own state
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("out_valid outside output state");
  // No item taken while a result waits
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("ready while result pending");
  // Failure only comes from an insert
  assert property (@(posedge clk) disable iff (rst) (out_valid && status) |-> op == CmdInsert)
    else $error("failure on non-insert");

endmodule
